// ===== design/bhd_pkg.sv =====
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared widths, defaults and command codes for the hop-distance search unit.
// ----------------------------------------------------------------------------
package bhd_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam int CMD_W    = 2;
   localparam int VERTEX_W = 4;
   localparam int WEIGHT_W = 16;
   localparam int HOP_W    = 4;
   localparam int COUNT_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
   localparam logic [HOP_W-1:0]   HOP_MAX     = 4'hF;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

endpackage

// ===== design/bhd_ram.sv =====
// ----------------------------------------------------------------------------
// bhd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bhd_ram #(
   parameter int WIDTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   localparam int DEPTH = 1 << AW;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bfs_hop_distance_adjacency_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// bfs_hop_distance_adjacency_matrix_unit
// Adjacency-matrix store with edge write/read and breadth-first hop search.
// ----------------------------------------------------------------------------
// After reset the unit sweeps all 4**ceil(log2(MAX_VERTICES)) adjacency RAM
// entries (256 at the default size) to zero, one entry a cycle; req_ready
// stays low during the sweep while csr writes are taken as usual. Afterwards
// one command is handled at a time. An edge write sends both symmetric
// entries through the single RAM write port, in S_WR1 and then S_WR2; an
// edge read goes through S_RD and S_RDW, and a bad-index or reserved command
// goes straight to S_EMIT. In a search every dequeued vertex scans one matrix
// row through the single adjacency read port, one entry per cycle, with one
// shared nonzero/unvisited test unit, then results leave one vertex at a time
// (one distance RAM read each). Results wait in an output register, and the
// unit holds while that register is full and rsp_ready is low.
// ----------------------------------------------------------------------------
module bfs_hop_distance_adjacency_matrix_unit #(
   parameter int MAX_VERTICES = bhd_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = bhd_pkg::WEIGHT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_wr_en,
   input  logic [bhd_pkg::COUNT_W-1:0]  csr_wr_data,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bhd_pkg::CMD_W-1:0]    req_command,
   input  logic [bhd_pkg::VERTEX_W-1:0] req_first_vertex,
   input  logic [bhd_pkg::VERTEX_W-1:0] req_second_vertex,
   input  logic signed [bhd_pkg::WEIGHT_W-1:0] req_edge_weight,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bhd_pkg::VERTEX_W-1:0] rsp_vertex,
   output logic signed [bhd_pkg::WEIGHT_W-1:0] rsp_weight_read,
   output logic                         rsp_edge_present,
   output logic [bhd_pkg::HOP_W-1:0]    rsp_hop_distance,
   output logic                         rsp_reached,
   output logic                         rsp_last,
   output logic                         rsp_bad_index
);

   import bhd_pkg::*;

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int ADJ_AW = 2 * VIDX_W;
   localparam int QUE_W  = VIDX_W + HOP_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WR1, S_WR2, S_RD, S_RDW, S_EMIT, S_INIT,
      S_DEQ, S_DEQW, S_SCAN, S_DRAIN, S_OUT_RD, S_OUT_LD
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]      count_ff;
   logic [ADJ_AW-1:0]       clr_ff, clr_in;
   logic [VIDX_W-1:0]       a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0]  wt_ff, wt_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic                    bad_ff, bad_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [CNT_W-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [VIDX_W-1:0]       u_ff, u_in, w_ff, w_in, v_ff, v_in;
   logic [HOP_W-1:0]        du_ff, du_in;
   logic                    chk_ff, chk_in;
   logic [VIDX_W-1:0]       chk_w_ff, chk_w_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic [WEIGHT_W-1:0]     rsp_weight_ff, rsp_weight_in;
   logic                    rsp_present_ff, rsp_present_in;
   logic [HOP_W-1:0]        rsp_hop_ff, rsp_hop_in;
   logic                    rsp_reached_ff, rsp_reached_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   // RAM ports
   logic                    adj_we;
   logic [ADJ_AW-1:0]       adj_waddr, adj_raddr;
   logic [WEIGHT_BITS-1:0]  adj_wdata, adj_rdata;
   logic                    q_we;
   logic [VIDX_W-1:0]       q_waddr;
   logic [QUE_W-1:0]        q_wdata, q_rdata;
   logic                    d_we;
   logic [VIDX_W-1:0]       d_waddr;
   logic [HOP_W-1:0]        d_wdata, d_rdata;

   // Derived values
   logic [CMP_W-1:0]        csr_ext, max_ext, eff_wide;
   logic [CNT_W-1:0]        eff_cnt;
   logic                    bad_first, bad_second;
   logic signed [31:0]      wt_wide;
   logic signed [WEIGHT_BITS-1:0] rd_signed;
   logic signed [31:0]      rd_wide;
   logic                    out_free, hit, last_w, last_v, accept;
   logic [HOP_W-1:0]        dnew;

   bhd_ram #(.WIDTH(WEIGHT_BITS), .AW(ADJ_AW)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   bhd_ram #(.WIDTH(QUE_W), .AW(VIDX_W)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[VIDX_W-1:0]),
      .rd_data (q_rdata)
   );

   bhd_ram #(.WIDTH(HOP_W), .AW(VIDX_W)) u_dist_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (v_ff),
      .rd_data (d_rdata)
   );

   // Vertex count in use: saturate to the built size, zero acts as one.
   assign csr_ext  = CMP_W'(count_ff);
   assign max_ext  = CMP_W'(MAX_VERTICES);
   assign eff_wide = (csr_ext > max_ext) ? max_ext :
                     ((csr_ext == '0) ? CMP_W'(1) : csr_ext);
   assign eff_cnt  = CNT_W'(eff_wide);

   assign bad_first  = CMP_W'(req_first_vertex) >= eff_wide;
   assign bad_second = CMP_W'(req_second_vertex) >= eff_wide;

   assign wt_wide   = 32'(req_edge_weight);
   assign rd_signed = adj_rdata;
   assign rd_wide   = 32'(rd_signed);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign last_w = (CNT_W'(w_ff) + CNT_W'(1)) == n_ff;
   assign last_v = (CNT_W'(v_ff) + CNT_W'(1)) == n_ff;

   assign dnew = (du_ff == HOP_MAX) ? HOP_MAX : du_ff + HOP_W'(1);
   assign hit  = chk_ff && (adj_rdata != '0) && !visited_ff[chk_w_ff];

   assign adj_raddr = ((state_ff == S_RD) || (state_ff == S_RDW)) ?
                      {a_ff, b_ff} : {w_ff, u_ff};

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      wt_in      = wt_ff;
      n_in       = n_ff;
      bad_in     = bad_ff;
      visited_in = visited_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      u_in       = u_ff;
      w_in       = w_ff;
      v_in       = v_ff;
      du_in      = du_ff;
      chk_in     = (state_ff == S_SCAN);
      chk_w_in   = w_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_vertex_in  = rsp_vertex_ff;
      rsp_weight_in  = rsp_weight_ff;
      rsp_present_in = rsp_present_ff;
      rsp_hop_in     = rsp_hop_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_bad_in     = rsp_bad_ff;

      adj_we    = 1'b0;
      adj_waddr = {a_ff, b_ff};
      adj_wdata = wt_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff[VIDX_W-1:0];
      q_wdata   = {chk_w_ff, dnew};
      d_we      = 1'b0;
      d_waddr   = chk_w_ff;
      d_wdata   = dnew;

      // Row test, in the cycle after the read is issued: enqueue new neighbors.
      if (hit) begin
         visited_in[chk_w_ff] = 1'b1;
         q_we    = 1'b1;
         d_we    = 1'b1;
         tail_in = tail_ff + CNT_W'(1);
      end

      case (state_ff)
         S_CLEAR: begin
            adj_we    = 1'b1;
            adj_waddr = clr_ff;
            adj_wdata = '0;
            clr_in    = clr_ff + ADJ_AW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               a_in    = VIDX_W'(req_first_vertex);
               b_in    = VIDX_W'(req_second_vertex);
               wt_in   = wt_wide[WEIGHT_BITS-1:0];
               n_in    = eff_cnt;
               bad_in  = 1'b0;
               head_in = '0;
               tail_in = '0;
               case (cmd_type'(req_command))
                  CMD_WRITE: begin
                     bad_in   = bad_first || bad_second;
                     state_in = (bad_first || bad_second) ? S_EMIT : S_WR1;
                  end
                  CMD_READ: begin
                     bad_in   = bad_first || bad_second;
                     state_in = (bad_first || bad_second) ? S_EMIT : S_RD;
                  end
                  CMD_SEARCH: begin
                     bad_in   = bad_first;
                     state_in = bad_first ? S_EMIT : S_INIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_WR1: begin
            adj_we   = 1'b1;
            state_in = S_WR2;
         end
         S_WR2: begin
            adj_we    = 1'b1;
            adj_waddr = {b_ff, a_ff};
            state_in  = S_EMIT;
         end
         S_RD: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_vertex_in  = '0;
               rsp_weight_in  = rd_wide[WEIGHT_W-1:0];
               rsp_present_in = (adj_rdata != '0);
               rsp_hop_in     = '0;
               rsp_reached_in = 1'b0;
               rsp_last_in    = 1'b1;
               rsp_bad_in     = 1'b0;
               state_in       = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_vertex_in  = '0;
               rsp_weight_in  = '0;
               rsp_present_in = 1'b0;
               rsp_hop_in     = '0;
               rsp_reached_in = 1'b0;
               rsp_last_in    = 1'b1;
               rsp_bad_in     = bad_ff;
               state_in       = S_IDLE;
            end
         end
         S_INIT: begin
            visited_in       = '0;
            visited_in[a_ff] = 1'b1;
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = {a_ff, HOP_W'(0)};
            d_we     = 1'b1;
            d_waddr  = a_ff;
            d_wdata  = '0;
            head_in  = '0;
            tail_in  = CNT_W'(1);
            state_in = S_DEQ;
         end
         S_DEQ: begin
            if (head_ff == tail_ff) begin
               v_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               state_in = S_DEQW;
            end
         end
         S_DEQW: begin
            u_in     = q_rdata[QUE_W-1:HOP_W];
            du_in    = q_rdata[HOP_W-1:0];
            head_in  = head_ff + CNT_W'(1);
            w_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (last_w) begin
               state_in = S_DRAIN;
            end else begin
               w_in = w_ff + VIDX_W'(1);
            end
         end
         S_DRAIN: begin
            // last row entry is tested this cycle
            state_in = S_DEQ;
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_vertex_in  = VERTEX_W'(v_ff);
               rsp_weight_in  = '0;
               rsp_present_in = 1'b0;
               rsp_hop_in     = visited_ff[v_ff] ? d_rdata : '0;
               rsp_reached_in = visited_ff[v_ff];
               rsp_last_in    = last_v;
               rsp_bad_in     = 1'b0;
               if (last_v) begin
                  state_in = S_IDLE;
               end else begin
                  v_in     = v_ff + VIDX_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= COUNT_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         n_ff         <= CNT_W'(1);
         chk_ff       <= 1'b0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         n_ff         <= n_in;
         chk_ff       <= chk_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff           <= a_in;
      b_ff           <= b_in;
      wt_ff          <= wt_in;
      bad_ff         <= bad_in;
      u_ff           <= u_in;
      w_ff           <= w_in;
      v_ff           <= v_in;
      du_ff          <= du_in;
      chk_w_ff       <= chk_w_in;
      rsp_vertex_ff  <= rsp_vertex_in;
      rsp_weight_ff  <= rsp_weight_in;
      rsp_present_ff <= rsp_present_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex       = rsp_vertex_ff;
   assign rsp_weight_read  = rsp_weight_ff;
   assign rsp_edge_present = rsp_present_ff;
   assign rsp_hop_distance = rsp_hop_ff;
   assign rsp_reached      = rsp_reached_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_bad_index    = rsp_bad_ff;

   // each vertex is queued at most once per search
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= n_ff)
      else $error("search queue tail passed the vertex count");

   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("search queue head passed the tail");

   a_busy_mid_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> !req_ready)
      else $error("new command taken before the search results finished");

   a_bad_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_last && !rsp_reached && !rsp_edge_present)
      else $error("bad index beat carries search or read data");

endmodule
